FILE: hw/rtl/cds_pkg.sv
// cds_pkg: shared types, constants and month tables for the calendar date step block.
// No dependencies; imported by cds_core and calendar_date_step.
`default_nettype none

package cds_pkg;

  localparam logic       KIND_NEXT = 1'b0;
  localparam logic       KIND_PREV = 1'b1;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [4:0] DAY_FIRST = 5'd1;
  localparam logic [4:0] FEB_DAYS  = 5'd28;

  // y / 25 == (y * RECIP_25) >> RECIP_SHIFT for every 16-bit y
  localparam logic [16:0] RECIP_25    = 17'd83887;
  localparam int          RECIP_SHIFT = 21;
  localparam int          PROD_W      = 33;
  localparam int          QUOT_W      = PROD_W - RECIP_SHIFT;

  // pipeline advance enables, one per register stage
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } cds_adv_t;

  // month length outside leap years, m in 1..12
  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // days in the year before the first of month m, non-leap
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cds_core.sv
// cds_core: three-stage datapath of the calendar date step block.
// Depends on cds_pkg; stage advance comes from the handshake logic in the top level.
`default_nettype none

module cds_core
  import cds_pkg::*;
(
  input  wire logic        clk,
  input  wire cds_adv_t    adv,
  input  wire logic        kind,
  input  wire logic [4:0]  in_day,
  input  wire logic [3:0]  in_month,
  input  wire logic [15:0] in_year,
  output logic      [4:0]  out_day,
  output logic      [3:0]  out_month,
  output logic      [15:0] out_year,
  output logic      [4:0]  month_length,
  output logic      [8:0]  ordinal_day,
  output logic             leap_year
);

  // stage 1: month saturation, table lookups, reciprocal product for /25
  logic               kind1_r;
  logic [4:0]         day1_r;
  logic [3:0]         mon1_r;
  logic [15:0]        year1_r;
  logic [PROD_W-1:0]  prod1_r;
  logic               div4_1_r;
  logic               div16_1_r;
  logic [4:0]         mlen1_r;
  logic [4:0]         plen1_r;
  logic               pfeb1_r;
  logic [8:0]         dbm1_r;

  logic [3:0] mon_sat;
  logic [3:0] mon_prev;

  always_comb begin
    if (in_month == 4'd0) begin
      mon_sat = MONTH_JAN;
    end else if (in_month > MONTH_DEC) begin
      mon_sat = MONTH_DEC;
    end else begin
      mon_sat = in_month;
    end
    mon_prev = (mon_sat == MONTH_JAN) ? MONTH_DEC : mon_sat - 4'd1;
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      kind1_r   <= kind;
      day1_r    <= in_day;
      mon1_r    <= mon_sat;
      year1_r   <= in_year;
      prod1_r   <= PROD_W'(in_year) * PROD_W'(RECIP_25);
      div4_1_r  <= (in_year[1:0] == 2'd0);
      div16_1_r <= (in_year[3:0] == 4'd0);
      mlen1_r   <= month_days(mon_sat);
      plen1_r   <= month_days(mon_prev);
      pfeb1_r   <= (mon_prev == MONTH_FEB);
      dbm1_r    <= days_before(mon_sat);
    end
  end

  // stage 2: leap decision, month length, day clamp, previous-month length
  logic        kind2_r;
  logic [4:0]  day2_r;
  logic [3:0]  mon2_r;
  logic [15:0] year2_r;
  logic [4:0]  len2_r;
  logic [4:0]  plen2_r;
  logic [8:0]  dbm2_r;
  logic        leap2_r;

  logic [QUOT_W-1:0] quot;
  logic [16:0]       quot25;
  logic              div25;
  logic              leap;
  logic [4:0]        feb_len;
  logic [4:0]        len;
  logic [4:0]        day_lo;
  logic [4:0]        day_cl;

  always_comb begin
    quot    = prod1_r[PROD_W-1:RECIP_SHIFT];
    quot25  = {1'b0, quot, 4'b0} + {2'b0, quot, 3'b0} + {5'b0, quot};
    div25   = (quot25 == {1'b0, year1_r});
    leap    = (div4_1_r & ~div25) | (div16_1_r & div25);
    feb_len = FEB_DAYS + {4'b0, leap};
    len     = (mon1_r == MONTH_FEB) ? feb_len : mlen1_r;
    day_lo  = (day1_r == 5'd0) ? DAY_FIRST : day1_r;
    day_cl  = (day_lo > len) ? len : day_lo;
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      kind2_r <= kind1_r;
      day2_r  <= day_cl;
      mon2_r  <= mon1_r;
      year2_r <= year1_r;
      len2_r  <= len;
      plen2_r <= pfeb1_r ? feb_len : plen1_r;
      dbm2_r  <= dbm1_r;
      leap2_r <= leap;
    end
  end

  // stage 3: ordinal day and neighbor date, registered as the result
  logic [4:0]  nd;
  logic [3:0]  nm;
  logic [15:0] ny;
  logic [8:0]  ord;

  always_comb begin
    ord = dbm2_r + {4'b0, day2_r} + {8'b0, (leap2_r && (mon2_r > MONTH_FEB))};
    nd  = day2_r;
    nm  = mon2_r;
    ny  = year2_r;
    if (kind2_r == KIND_NEXT) begin
      if (day2_r >= len2_r) begin
        nd = DAY_FIRST;
        if (mon2_r == MONTH_DEC) begin
          nm = MONTH_JAN;
          ny = year2_r + 16'd1;
        end else begin
          nm = mon2_r + 4'd1;
        end
      end else begin
        nd = day2_r + 5'd1;
      end
    end else begin
      if (day2_r <= DAY_FIRST) begin
        nd = plen2_r;
        if (mon2_r == MONTH_JAN) begin
          nm = MONTH_DEC;
          ny = year2_r - 16'd1;
        end else begin
          nm = mon2_r - 4'd1;
        end
      end else begin
        nd = day2_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      out_day      <= nd;
      out_month    <= nm;
      out_year     <= ny;
      month_length <= len2_r;
      ordinal_day  <= ord;
      leap_year    <= leap2_r;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/calendar_date_step.sv
// calendar_date_step: top level, stream handshake and valid pipeline around cds_core.
// Depends on cds_pkg and cds_core.
`default_nettype none

// Gives the next (in_tuser = 0) or previous (in_tuser = 1) Gregorian date of the
// requested date, with the month length, leap flag and ordinal day of the requested
// date. Months outside 1..12 saturate, day 0 reads as 1 and a day past month end
// reads as the last day; the year wraps modulo 65536. One request is taken per
// cycle while the output is not stalled; each accepted request passes through the
// three register stages (decode and /25 product, leap and clamp, result).
// Each stage holds under backpressure, so a stall drops or repeats nothing.
module calendar_date_step
  import cds_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // in_day[4:0], in_month[8:5], in_year[24:9], 0
  input  wire logic        in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata   // out_day[4:0], out_month[8:5], out_year[24:9],
                                       // month_length[29:25], ordinal_day[38:30],
                                       // leap_year[39]
);

  logic     v1_r, v2_r, v3_r;
  cds_adv_t adv;

  always_comb begin
    adv.s3 = ~v3_r | out_tready;
    adv.s2 = ~v2_r | adv.s3;
    adv.s1 = ~v1_r | adv.s2;
  end

  assign in_tready  = adv.s1;
  assign out_tvalid = v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv.s1) v1_r <= in_tvalid;
      if (adv.s2) v2_r <= v1_r;
      if (adv.s3) v3_r <= v2_r;
    end
  end

  logic [4:0]  res_day;
  logic [3:0]  res_month;
  logic [15:0] res_year;
  logic [4:0]  res_len;
  logic [8:0]  res_ord;
  logic        res_leap;

  cds_core u_core (
    .clk          (clk),
    .adv          (adv),
    .kind         (in_tuser),
    .in_day       (in_tdata[4:0]),
    .in_month     (in_tdata[8:5]),
    .in_year      (in_tdata[24:9]),
    .out_day      (res_day),
    .out_month    (res_month),
    .out_year     (res_year),
    .month_length (res_len),
    .ordinal_day  (res_ord),
    .leap_year    (res_leap)
  );

  assign out_tdata = {res_leap, res_ord, res_len, res_year, res_month, res_day};

endmodule

`default_nettype wire

FILE: hw/rtl/cds_checker.sv
// cds_checker: port-level assertions for calendar_date_step, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none

module cds_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_len_leap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[29:25] != 5'd29 || out_tdata[39]) &&
                   (out_tdata[38:30] != 9'd366 || out_tdata[39]))
    else $error("leap-only value without leap flag");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[8:5] >= 4'd1 && out_tdata[8:5] <= 4'd12 &&
                   out_tdata[4:0] >= 5'd1 && out_tdata[29:25] >= 5'd28 &&
                   out_tdata[29:25] <= 5'd31 && out_tdata[38:30] >= 9'd1)
    else $error("result field out of range");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tvalid ##1 !in_tvalid ##1 !in_tvalid ##1 !out_tvalid |=> !out_tvalid)
    else $error("result without request");

endmodule

bind calendar_date_step cds_checker u_cds_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

FILE: verif/date_scoreboard_pkg.sv
// date_scoreboard_pkg: date-step predictor and scoreboard class for calendar_date_step_tb.
// Depends on cds_pkg for direction, month and day constants.
`default_nettype none

package date_scoreboard_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import cds_pkg::*;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [4:0]  mlen;
    logic [8:0]  ordinal;
    logic        leap;
  } date_result_t;

  class date_scoreboard;
    date_result_t pending_dates[$];
    int unsigned  failures;
    int unsigned  days_plain[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    int unsigned  days_ahead[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    function new();
      failures = 0;
    endfunction

    function bit is_leap(logic [15:0] y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    // m must already be in 1..12
    function logic [4:0] month_len(logic [3:0] m, bit leap);
      logic [4:0] len;
      len = 5'(days_plain[m - 1]);
      if (m == MONTH_FEB && leap) len = 5'd29;
      return len;
    endfunction

    function date_result_t step_date(logic kind, logic [4:0] d_in, logic [3:0] m_in,
                                     logic [15:0] y);
      logic [3:0]   m;
      logic [4:0]   d;
      logic [4:0]   len;
      bit           leap;
      date_result_t r;
      m = m_in;
      if (m == 4'd0) m = MONTH_JAN;
      if (m > MONTH_DEC) m = MONTH_DEC;
      leap = is_leap(y);
      len = month_len(m, leap);
      d = d_in;
      if (d == 5'd0) d = DAY_FIRST;
      if (d > len) d = len;

      r.mlen = len;
      r.leap = leap;
      r.ordinal = 9'(days_ahead[m - 1]) + 9'(d) + ((leap && m > MONTH_FEB) ? 9'd1 : 9'd0);
      r.day = d;
      r.month = m;
      r.year = y;
      if (kind == KIND_NEXT) begin
        if (d >= len) begin
          r.day = DAY_FIRST;
          if (m == MONTH_DEC) begin
            r.month = MONTH_JAN;
            r.year = y + 16'd1;
          end else begin
            r.month = m + 4'd1;
          end
        end else begin
          r.day = d + 5'd1;
        end
      end else begin
        if (d <= DAY_FIRST) begin
          if (m == MONTH_JAN) begin
            r.month = MONTH_DEC;
            r.year = y - 16'd1;
          end else begin
            r.month = m - 4'd1;
          end
          r.day = month_len(r.month, leap);
        end else begin
          r.day = d - 5'd1;
        end
      end
      return r;
    endfunction

    function void note_request(logic kind, logic [4:0] d, logic [3:0] m, logic [15:0] y);
      pending_dates = {pending_dates, step_date(kind, d, m, y)};
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0d ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [39:0] word);
      date_result_t want;
      if (pending_dates.size() == 0) begin
        $display("%0d ns: unexpected result, expected none, actual %h", $time, word);
        failures++;
        return;
      end
      want = pending_dates.pop_front();
      compare_field("out_day",      want.day,     word[4:0]);
      compare_field("out_month",    want.month,   word[8:5]);
      compare_field("out_year",     want.year,    word[24:9]);
      compare_field("month_length", want.mlen,    word[29:25]);
      compare_field("ordinal_day",  want.ordinal, word[38:30]);
      compare_field("leap_year",    want.leap,    word[39]);
    endfunction
  endclass

endpackage

`default_nettype wire

FILE: verif/calendar_date_step_tb.sv
// calendar_date_step_tb: drives date requests through calendar_date_step with random
// idling on both sides and checks every result against date_scoreboard.
// Depends on cds_pkg, date_scoreboard_pkg and the calendar_date_step RTL.
`default_nettype none

module calendar_date_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cds_pkg::*;
  import date_scoreboard_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = KIND_NEXT;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  bit          steady = 1'b0;

  date_scoreboard board = new();

  calendar_date_step uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 31);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  // called right after a rising edge; returns right after the request is taken
  task automatic push_request(input logic kind, input logic [4:0] d, input logic [3:0] m,
                              input logic [15:0] y);
    while (!steady && $urandom_range(0, 99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {7'd0, y, m, d};
    do @(posedge clk); while (!in_tready);
    board.note_request(kind, d, m, y);
  endtask

  initial begin
    logic [15:0] corner_years[10];
    logic        kind;
    logic [4:0]  d;
    logic [3:0]  m;
    logic [15:0] y;
    logic [4:0]  len;
    int unsigned pick;
    int unsigned drain;

    corner_years = '{16'd0, 16'd4, 16'd100, 16'd400, 16'd1900, 16'd2000,
                     16'd2100, 16'd2400, 16'd65532, 16'd65535};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_request(KIND_NEXT, 5'd31, 4'd12, 16'd65535);
    push_request(KIND_PREV, 5'd1,  4'd1,  16'd0);
    push_request(KIND_NEXT, 5'd28, 4'd2,  16'd2000);
    push_request(KIND_NEXT, 5'd29, 4'd2,  16'd2000);
    push_request(KIND_PREV, 5'd1,  4'd3,  16'd2000);
    push_request(KIND_PREV, 5'd1,  4'd3,  16'd1900);
    push_request(KIND_NEXT, 5'd29, 4'd2,  16'd1900);
    push_request(KIND_NEXT, 5'd0,  4'd5,  16'd2024);
    push_request(KIND_PREV, 5'd31, 4'd4,  16'd2023);
    push_request(KIND_NEXT, 5'd15, 4'd0,  16'd100);
    push_request(KIND_PREV, 5'd15, 4'd15, 16'd400);
    push_request(KIND_NEXT, 5'd31, 4'd13, 16'd65535);
    push_request(KIND_PREV, 5'd0,  4'd0,  16'd0);
    push_request(KIND_NEXT, 5'd31, 4'd1,  16'd2023);
    push_request(KIND_PREV, 5'd1,  4'd2,  16'd2024);
    push_request(KIND_NEXT, 5'd30, 4'd6,  16'd2100);
    push_request(KIND_PREV, 5'd1,  4'd12, 16'd2400);
    push_request(KIND_NEXT, 5'd31, 4'd12, 16'd2024);
    push_request(KIND_PREV, 5'd1,  4'd1,  16'd65535);
    push_request(KIND_NEXT, 5'd29, 4'd2,  16'd65532);
    push_request(KIND_PREV, 5'd31, 4'd10, 16'd32768);
    push_request(KIND_NEXT, 5'd16, 4'd9,  16'h5555);
    push_request(KIND_PREV, 5'd10, 4'd10, 16'hAAAA);
    push_request(KIND_NEXT, 5'd31, 4'd14, 16'hFFFF);

    for (int i = 0; i < 750; i++) begin
      steady = (i >= 300 && i < 450);
      kind = $urandom_range(0, 1) ? KIND_PREV : KIND_NEXT;
      if ($urandom_range(0, 99) < 80) begin
        y = ($urandom_range(0, 99) < 30) ? corner_years[$urandom_range(0, 9)]
                                          : 16'($urandom);
        m = 4'($urandom_range(1, 12));
        len = board.month_len(m, board.is_leap(y));
        pick = $urandom_range(0, 99);
        if (pick < 30) d = DAY_FIRST;
        else if (pick < 60) d = len;
        else d = 5'($urandom_range(1, len));
      end else begin
        y = 16'($urandom);
        m = 4'($urandom_range(0, 15));
        d = 5'($urandom_range(0, 31));
      end
      push_request(kind, d, m, y);
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    drain = 0;
    while (board.pending_dates.size() != 0 && drain < 4000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (board.pending_dates.size() != 0) begin
      $display("%0d ns: results missing, expected %0d more, actual 0", $time,
               board.pending_dates.size());
      board.failures++;
    end

    if (board.failures == 0) begin
      $display("calendar_date_step_tb passed");
    end else begin
      $display("calendar_date_step_tb failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("calendar_date_step_tb failed");
    $finish;
  end

endmodule

`default_nettype wire
